### src/kmcd_pkg.sv
package kmcd_pkg;

    localparam int ROWS    = 8;
    localparam int COLUMNS = 8;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 3;
    localparam int SLOTS  = 2 * ROWS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [COL_W-1:0] COL_MASK = COL_W'((1 << COLUMNS) - 1);

    typedef struct packed {
        logic             half;
        logic [ROW_W-1:0] row_number;
        logic [COL_W-1:0] column_bits;
    } item_t;

    typedef struct packed {
        logic             event_half;
        logic [ROW_W-1:0] event_row;
        logic [2:0]       event_column;
        logic             pressed;
        logic             last;
    } event_t;

    // Row comparison handed from the store to the shifter.
    typedef struct packed {
        logic             load;
        logic             half;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] diff;
        logic [COL_W-1:0] bits;
    } load_t;

endpackage

### src/kmcd_row_store.sv
module kmcd_row_store (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            write,
    input  kmcd_pkg::item_t item,
    output kmcd_pkg::load_t ld
);
    import kmcd_pkg::*;

    logic [COL_W-1:0]  rows_reg [SLOTS];
    logic [SLOT_W-1:0] slot;
    logic              in_range;
    logic [COL_W-1:0]  bits;

    assign in_range = (32'(item.row_number) < ROWS);
    assign slot     = SLOT_W'(32'(item.half) * ROWS + 32'(item.row_number));
    assign bits     = item.column_bits & COL_MASK;

    always_comb
    begin
        ld.load = write && in_range;
        ld.half = item.half;
        ld.row  = item.row_number;
        ld.bits = bits;
        ld.diff = in_range ? (rows_reg[slot] ^ bits) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else if (write && in_range)
        begin
            rows_reg[slot] <= bits;
        end
    end

endmodule

### src/kmcd_event_shifter.sv
module kmcd_event_shifter (
    input  logic             clk,
    input  logic             rst_n,
    input  kmcd_pkg::load_t  ld,
    output logic             busy,
    output logic             out_valid,
    input  logic             out_stall,
    output kmcd_pkg::event_t out_data
);
    import kmcd_pkg::*;

    logic [COL_W-1:0] diff_reg;
    logic [COL_W-1:0] bits_reg;
    logic [2:0]       col_reg;
    logic             half_reg;
    logic [ROW_W-1:0] row_reg;
    logic             valid_reg;
    event_t           data_reg;
    logic             adv;
    logic             emit;

    assign busy = (diff_reg != '0);
    // a zero bit shifts out freely; a set bit needs room in the output register
    assign adv  = busy && (!diff_reg[0] || !valid_reg || !out_stall);
    assign emit = adv && diff_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (ld.load)
            begin
                diff_reg <= ld.diff;
            end
            else if (adv)
            begin
                diff_reg <= diff_reg >> 1;
            end

            if (emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            bits_reg <= ld.bits;
            col_reg  <= '0;
            half_reg <= ld.half;
            row_reg  <= ld.row;
        end
        else if (adv)
        begin
            bits_reg <= bits_reg >> 1;
            col_reg  <= col_reg + 3'd1;
        end

        if (emit)
        begin
            data_reg.event_half   <= half_reg;
            data_reg.event_row    <= row_reg;
            data_reg.event_column <= col_reg;
            data_reg.pressed      <= bits_reg[0];
            data_reg.last         <= ((diff_reg >> 1) == '0);
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### src/key_matrix_change_detector.sv
// Keyboard matrix change detector. Each input transaction is one scanned row; the
// block compares it with the stored state of that row (cleared at reset, all keys
// released) and emits one event per changed column, lowest column first, with last
// set on the final one. A row is accepted only while no walk is pending; a shift register then
// walks the difference one column per cycle unless out_stall holds it, and stops after the
// highest changed column, so an unchanged row starts no walk. in_stall is held while that
// shift register still holds changed columns, and out_stall holds the walk only when the
// next column has an event to deliver.
module key_matrix_change_detector (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  kmcd_pkg::item_t  in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output kmcd_pkg::event_t out_data
);
    import kmcd_pkg::*;

    load_t ld;
    logic  busy;
    logic  in_take;

    assign in_stall = busy;
    assign in_take  = in_valid && !busy;

    kmcd_row_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .write (in_take),
        .item  (in_data),
        .ld    (ld)
    );

    kmcd_event_shifter u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld        (ld),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // an event that is not the last one leaves changed columns still to walk
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> busy)
        else $error("non-last event pending with no columns left");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_data.event_column) < COLUMNS))
        else $error("event column beyond matrix");

    // a row that differs from the store must start a walk
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && ld.load && (ld.diff != '0) |=> busy)
        else $error("changed row did not start a walk");

endmodule
